// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker module dctp_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge, off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== src/dctp_pkg.sv =====
// ---------------------------------------------------------------------------
// dctp_pkg
// Types, constants and helpers for the drive command text parser.
// ---------------------------------------------------------------------------
package dctp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;

  // Pattern "F:%d B:%d R:%d L:%d PX:%d PY:%d", position 31 marks its end
  localparam logic [4:0] PAT_END = 5'd31;
  // Pattern positions walked for one byte at most (number end, space, literal)
  localparam int unsigned STEP_MAX = 3;

  localparam logic [2:0] MIN_DRIVE = 3'd4;
  localparam logic [2:0] ALL_MATCH = 3'd6;
  localparam logic [2:0] CNT_MAX   = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_D     = 8'h64;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_HALT       = 4'd1,
    CMD_FWD_LEFT   = 4'd2,
    CMD_FWD_RIGHT  = 4'd3,
    CMD_BACK_LEFT  = 4'd4,
    CMD_BACK_RIGHT = 4'd5,
    CMD_FWD        = 4'd6,
    CMD_BACK       = 4'd7,
    CMD_TURN_LEFT  = 4'd8,
    CMD_TURN_RIGHT = 4'd9
  } cmd_type_e;

  // Summary of one parsed drive value: enough to classify and report it
  typedef struct packed {
    logic       zero;
    logic       pos;
    logic [7:0] low;
  } drive_t;

  // One finished line, handed from the parser to the classifier
  typedef struct packed {
    logic            stop;
    logic [2:0]      matched;
    drive_t [3:0]    drive;   // F, B, R, L at index 0..3
    logic [1:0][7:0] pan;     // PX, PY at index 0..1
  } rec_t;

  // Result item, cmd_type in the lowest bits
  typedef struct packed {
    logic signed [7:0] pan_y;
    logic signed [7:0] pan_x;
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic signed [7:0] backward_speed;
    logic signed [7:0] forward_speed;
    cmd_type_e         cmd_type;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  function automatic logic [7:0] pattern_char(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:  ch = 8'h46;  // F
      5'd1:  ch = 8'h3A;  // :
      5'd2:  ch = CH_PCT;
      5'd3:  ch = CH_D;
      5'd4:  ch = CH_SPACE;
      5'd5:  ch = 8'h42;  // B
      5'd6:  ch = 8'h3A;
      5'd7:  ch = CH_PCT;
      5'd8:  ch = CH_D;
      5'd9:  ch = CH_SPACE;
      5'd10: ch = 8'h52;  // R
      5'd11: ch = 8'h3A;
      5'd12: ch = CH_PCT;
      5'd13: ch = CH_D;
      5'd14: ch = CH_SPACE;
      5'd15: ch = 8'h4C;  // L
      5'd16: ch = 8'h3A;
      5'd17: ch = CH_PCT;
      5'd18: ch = CH_D;
      5'd19: ch = CH_SPACE;
      5'd20: ch = 8'h50;  // P
      5'd21: ch = 8'h58;  // X
      5'd22: ch = 8'h3A;
      5'd23: ch = CH_PCT;
      5'd24: ch = CH_D;
      5'd25: ch = CH_SPACE;
      5'd26: ch = 8'h50;  // P
      5'd27: ch = 8'h59;  // Y
      5'd28: ch = 8'h3A;
      5'd29: ch = CH_PCT;
      5'd30: ch = CH_D;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

endpackage

// ===== src/dctp_front.sv =====
// ---------------------------------------------------------------------------
// dctp_front
// Byte parser: walks the command pattern one byte per cycle while the queue
// is not full, and pushes a line summary into the queue on the last byte.
// ---------------------------------------------------------------------------
module dctp_front #(
  parameter int unsigned VALUE_BITS = dctp_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     char_code_i,
  input  logic           end_of_command_i,
  input  logic           full_i,
  output logic           push_o,
  output dctp_pkg::rec_t rec_o
);
  import dctp_pkg::*;

  logic [4:0]            pos_q;
  logic                  first_q, stop_q, halted_q, neg_q, digit_q;
  logic [VALUE_BITS-1:0] run_q, run_d;
  logic [2:0]            cnt_q, cnt_d;
  drive_t [3:0]          drive_q, drive_d;
  logic [1:0][7:0]       pan_q, pan_d;

  logic [4:0]            p;
  logic                  hl, ng, dg, take, fin, done, stp;
  logic [7:0]            pc;
  logic [VALUE_BITS-1:0] acc, mag;
  drive_t                summ;
  logic                  accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && end_of_command_i;

  // times ten plus digit, wraps at the value width
  assign acc = (run_q << 3) + (run_q << 1) + {{(VALUE_BITS-4){1'b0}}, char_code_i[3:0]};

  always_comb begin
    stp  = stop_q;
    hl   = halted_q;
    p    = pos_q;
    ng   = neg_q;
    dg   = digit_q;
    take = 1'b0;
    fin  = 1'b0;
    done = 1'b0;
    pc   = CH_NUL;
    if (first_q && char_code_i == CH_S) begin
      stp = 1'b1;
      hl  = 1'b1;
    end
    if (!hl && char_code_i != CH_NUL) begin
      for (int i = 0; i < STEP_MAX; i++) begin
        if (!done && !hl) begin
          if (p == PAT_END) begin
            hl   = 1'b1;
            done = 1'b1;
          end else begin
            pc = pattern_char(p);
            case (pc)
              CH_SPACE: begin
                if (is_space(char_code_i)) done = 1'b1;
                else p = p + 5'd1;
              end
              CH_PCT: begin
                if (is_space(char_code_i)) begin
                  done = 1'b1;
                end else begin
                  p = p + 5'd1;
                  if (char_code_i inside {CH_PLUS, CH_MINUS}) begin
                    ng   = (char_code_i == CH_MINUS);
                    done = 1'b1;
                  end
                end
              end
              CH_D: begin
                if (is_digit(char_code_i)) begin
                  take = 1'b1;
                  dg   = 1'b1;
                  done = 1'b1;
                end else if (!dg) begin
                  hl   = 1'b1;
                  done = 1'b1;
                end else begin
                  fin = 1'b1;
                  dg  = 1'b0;
                  ng  = 1'b0;
                  p   = p + 5'd1;
                end
              end
              default: begin
                if (char_code_i == pc) p = p + 5'd1;
                else hl = 1'b1;
                done = 1'b1;
              end
            endcase
          end
        end
      end
    end
    // zero byte or end of line: a number with digits is complete
    if (char_code_i == CH_NUL || end_of_command_i) begin
      if (!hl && p != PAT_END && pattern_char(p) == CH_D && dg) begin
        fin = 1'b1;
        dg  = 1'b0;
        ng  = 1'b0;
        p   = p + 5'd1;
      end
      hl = 1'b1;
    end
  end

  // Value being finished, sign taken from the number's own prefix
  always_comb begin
    mag       = take ? acc : run_q;
    summ.zero = (mag == '0);
    summ.pos  = neg_q ? (mag[VALUE_BITS-1] && (|mag[VALUE_BITS-2:0]))
                      : (!summ.zero && !mag[VALUE_BITS-1]);
    summ.low  = neg_q ? (~mag[7:0] + 8'd1) : mag[7:0];
  end

  always_comb begin
    drive_d = drive_q;
    pan_d   = pan_q;
    cnt_d   = cnt_q;
    run_d   = fin ? '0 : mag;
    if (fin) begin
      if (cnt_q < MIN_DRIVE) drive_d[cnt_q[1:0]] = summ;
      else if (cnt_q < ALL_MATCH) pan_d[cnt_q[0]] = summ.low;
      if (cnt_q != CNT_MAX) cnt_d = cnt_q + 3'd1;
    end
  end

  always_comb begin
    rec_o.stop    = stp;
    rec_o.matched = cnt_d;
    rec_o.drive   = drive_d;
    rec_o.pan     = pan_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      first_q  <= 1'b1;
      stop_q   <= 1'b0;
      halted_q <= 1'b0;
      neg_q    <= 1'b0;
      digit_q  <= 1'b0;
      run_q    <= '0;
      cnt_q    <= '0;
      drive_q  <= '0;
      pan_q    <= '0;
    end else if (accept) begin
      if (end_of_command_i) begin
        pos_q    <= '0;
        first_q  <= 1'b1;
        stop_q   <= 1'b0;
        halted_q <= 1'b0;
        neg_q    <= 1'b0;
        digit_q  <= 1'b0;
        run_q    <= '0;
        cnt_q    <= '0;
        drive_q  <= '0;
        pan_q    <= '0;
      end else begin
        pos_q    <= p;
        first_q  <= 1'b0;
        stop_q   <= stp;
        halted_q <= hl;
        neg_q    <= ng;
        digit_q  <= dg;
        run_q    <= run_d;
        cnt_q    <= cnt_d;
        drive_q  <= drive_d;
        pan_q    <= pan_d;
      end
    end
  end

endmodule

// ===== src/dctp_fifo.sv =====
// ---------------------------------------------------------------------------
// dctp_fifo
// Short queue of finished line summaries between parser and classifier.
// ---------------------------------------------------------------------------
module dctp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dctp_pkg::rec_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dctp_pkg::rec_t data_o
);
  import dctp_pkg::*;

  localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_PTR_W:0]   CNT_FULL = (FIFO_PTR_W + 1)'(FIFO_DEPTH);

  rec_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== src/dctp_back.sv =====
// ---------------------------------------------------------------------------
// dctp_back
// Classifier: picks the command type for a finished line and holds the
// result in the output register until it is taken.
// ---------------------------------------------------------------------------
module dctp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  input  dctp_pkg::rec_t rec_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dctp_pkg::res_t res_o
);
  import dctp_pkg::*;

  logic valid_q;
  res_t res_q, res_d;
  logic f_pos, b_pos, r_pos, l_pos, all_zero;

  assign pop_o       = rec_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  assign f_pos    = rec_i.drive[0].pos;
  assign b_pos    = rec_i.drive[1].pos;
  assign r_pos    = rec_i.drive[2].pos;
  assign l_pos    = rec_i.drive[3].pos;
  assign all_zero = rec_i.drive[0].zero && rec_i.drive[1].zero &&
                    rec_i.drive[2].zero && rec_i.drive[3].zero;

  always_comb begin
    res_d = '0;
    res_d.cmd_type = CMD_NONE;
    if (rec_i.stop) begin
      res_d.cmd_type = CMD_HALT;
    end else if (rec_i.matched >= MIN_DRIVE) begin
      res_d.forward_speed  = rec_i.drive[0].low;
      res_d.backward_speed = rec_i.drive[1].low;
      res_d.right_speed    = rec_i.drive[2].low;
      res_d.left_speed     = rec_i.drive[3].low;
      if (rec_i.matched >= ALL_MATCH) begin
        res_d.pan_x = rec_i.pan[0];
        res_d.pan_y = rec_i.pan[1];
      end
      if (all_zero)            res_d.cmd_type = CMD_HALT;
      else if (f_pos && l_pos) res_d.cmd_type = CMD_FWD_LEFT;
      else if (f_pos && r_pos) res_d.cmd_type = CMD_FWD_RIGHT;
      else if (b_pos && l_pos) res_d.cmd_type = CMD_BACK_LEFT;
      else if (b_pos && r_pos) res_d.cmd_type = CMD_BACK_RIGHT;
      else if (f_pos)          res_d.cmd_type = CMD_FWD;
      else if (b_pos)          res_d.cmd_type = CMD_BACK;
      else if (l_pos)          res_d.cmd_type = CMD_TURN_LEFT;
      else if (r_pos)          res_d.cmd_type = CMD_TURN_RIGHT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

endmodule

// ===== src/drive_command_text_parser.sv =====
// ---------------------------------------------------------------------------
// drive_command_text_parser
// Parses one ASCII drive command line per frame into a drive result.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one command byte per transaction in s_axis_tdata[7:0],
//   s_axis_tlast on the final byte of the line. Master stream: one result
//   transaction per line, fields packed in m_axis_tdata (see port list).
//   Throughput: one byte per cycle while s_axis_tready is high, including
//   back-to-back lines. The tlast transaction pushes the line summary into the
//   queue; m_axis_tvalid rises once the classifier registers its result.
//   The parser walks the pattern one byte a cycle while the queue has room; a
//   two-entry queue sits between it and the classifier's output register, so up
//   to three results may wait while m_axis_tready is low. s_axis_tready drops
//   only when the queue is full, with the output register holding a result.
//   Reset puts the parser at the start of a line and empties queue and
//   output register; no clearing pass is needed.
//   VALUE_BITS sets the wrap width of parsed numbers.
// ---------------------------------------------------------------------------
module drive_command_text_parser #(
  parameter int unsigned VALUE_BITS = dctp_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dctp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] char_code
  input  logic                                s_axis_tlast,  // end_of_command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] cmd_type, [11:4] forward_speed, [19:12] backward_speed,
  // [27:20] right_speed, [35:28] left_speed, [43:36] pan_x, [51:44] pan_y
  output logic [dctp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import dctp_pkg::*;

  logic full, push, rec_valid, pop;
  rec_t rec_in, rec_out;
  res_t res;

  dctp_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .char_code_i     (s_axis_tdata[7:0]),
    .end_of_command_i(s_axis_tlast),
    .full_i          (full),
    .push_o          (push),
    .rec_o           (rec_in)
  );

  dctp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rec_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(rec_valid),
    .data_o (rec_out)
  );

  dctp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(rec_valid),
    .rec_i      (rec_out),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, res};

endmodule

// ===== src/dctp_checker.sv =====
// ---------------------------------------------------------------------------
// dctp_checker
// Port-level checks for the drive command text parser, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dctp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dctp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import dctp_pkg::*;

  res_t res;
  logic in_last, out_stall, out_stop, speeds_zero;

  assign res         = m_axis_tdata[RES_W-1:0];
  assign in_last     = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_stop    = m_axis_tvalid && (res.cmd_type == CMD_HALT);
  assign speeds_zero = (res.forward_speed == 8'sd0) && (res.backward_speed == 8'sd0) &&
                       (res.right_speed == 8'sd0) && (res.left_speed == 8'sd0);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stall hold")

  // a fresh result only shows up after an accepted line end
  `ASSERT_IMPLY(a_out_after_last, $rose(m_axis_tvalid), $past(in_last, 2), "no line end")

  // input only backs up while the output holds a result
  `ASSERT_IMPLY(a_ready_low, !s_axis_tready, m_axis_tvalid, "input stalled with output idle")

  // stop never carries a drive speed
  `ASSERT_IMPLY(a_stop_zero, out_stop, speeds_zero, "stop with nonzero speed")

endmodule

bind drive_command_text_parser dctp_checker u_dctp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
